// ----- hdl/ebc_pkg.sv -----
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared constants, codes and types for the entropy bit collector.
// ----------------------------------------------------------------------------
package ebc_pkg;

    // Store geometry: bits are held eight to a row, earliest bit in the MSB.
    localparam int STORE_BITS = 256;
    localparam int STORE_ROWS = STORE_BITS / 8;
    localparam int ROW_W      = $clog2(STORE_ROWS);

    // Field widths fixed by the interface.
    localparam int CNT_W  = 9;
    localparam int EXT_W  = CNT_W + 1;
    localparam int MOD_W  = 4;

    localparam logic [CNT_W-1:0] TARGET_RESET = 9'd256;

    // A die roll keeps its second bit only if the count after the first
    // bit is not a multiple of this.
    localparam logic [MOD_W-1:0] DIE_SPLIT = 4'd11;
    localparam logic [MOD_W-1:0] MOD_LAST  = DIE_SPLIT - 4'd1;

    // Operation codes.
    localparam logic [2:0] OP_RAW   = 3'd0;
    localparam logic [2:0] OP_PAIR  = 3'd1;
    localparam logic [2:0] OP_DIE   = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Pair extractor status codes.
    localparam logic [2:0] PS_WAIT    = 3'd0;
    localparam logic [2:0] PS_DROP    = 3'd1;
    localparam logic [2:0] PS_ADD0    = 3'd2;
    localparam logic [2:0] PS_ADD1    = 3'd3;
    localparam logic [2:0] PS_NO_PAIR = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SPILL
    } st_t;

    // Access request from the sequencer to the bit store.
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [7:0]       wr_data;
        logic             clr;
    } store_req_t;

endpackage

// ----- hdl/ebc_store.sv -----
// ----------------------------------------------------------------------------
// ebc_store
// Row memory for the collected bits with one valid flag per row.
// ----------------------------------------------------------------------------
module ebc_store
    import ebc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output logic [7:0] rd_data
);

    logic [7:0]            mem [STORE_ROWS];
    logic [7:0]            mem_q_reg;
    logic [STORE_ROWS-1:0] row_valid_reg;
    logic [STORE_ROWS-1:0] row_valid_next;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;

    // Synchronous memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_row] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.rd_row];
        end
    end

    // Row valid flags: a clear drops them all, a write marks its row.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (req.clr)
        begin
            row_valid_next = '0;
        end
        else if (req.wr_en)
        begin
            row_valid_next[req.wr_row] = 1'b1;
        end
    end

    // The valid flag of the row being read travels with the read data.
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (req.rd_en)
        begin
            rd_valid_next = row_valid_reg[req.rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    // A row that was never written since the last clear reads as zeros.
    assign rd_data = rd_valid_reg ? mem_q_reg : 8'h00;

endmodule

// ----- hdl/ebc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ebc_ctrl
// Command decode, pair extractor, counters and the read-modify-write
// sequencer for the bit store.
// ----------------------------------------------------------------------------
module ebc_ctrl
    import ebc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       op,
    input  logic [7:0]       value,
    input  logic [4:0]       byte_index,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic [7:0]       rd_data,
    output logic             busy,
    output logic             done,
    output logic [2:0]       pair_status,
    output logic [1:0]       dice_bits_added,
    output logic [CNT_W-1:0] bits_held,
    output logic             target_reached,
    output logic [7:0]       read_data,
    output store_req_t       req
);

    // Architectural state.
    st_t              state_reg, state_next;
    logic [CNT_W-1:0] target_reg, target_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic             pend_reg, pend_next;
    logic             first_reg, first_next;

    // Command held while the store is updated.
    logic [1:0]       nadd_reg, nadd_next;
    logic             bit_a_reg, bit_a_next;
    logic             bit_b_reg, bit_b_next;
    logic [2:0]       off_reg, off_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             rd_op_reg, rd_op_next;

    // Result registers.
    logic             done_reg, done_next;
    logic [2:0]       status_reg, status_next;
    logic [1:0]       dice_reg, dice_next;
    logic             reached_reg, reached_next;
    logic [7:0]       rdata_reg, rdata_next;

    logic             accept;
    logic             spill;
    logic             coin;
    logic [EXT_W-1:0] total_ext;
    logic [EXT_W-1:0] tgt_ext;
    logic             has_room;
    logic             tgt_ok;
    logic [1:0]       code;
    logic [1:0]       add_n;
    logic             add_a;
    logic             add_b;
    logic [MOD_W-1:0] mod_sum;
    logic [7:0]       mask_a;
    logic [7:0]       mask_b;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign coin      = (value != 8'd0);
    assign total_ext = {1'b0, total_reg};
    assign tgt_ext   = {1'b0, target_reg};
    assign has_room  = total_ext < EXT_W'(STORE_BITS);
    assign tgt_ok    = (target_reg != '0) && (tgt_ext <= EXT_W'(STORE_BITS));
    assign code      = 2'(value - 8'd1);
    assign spill     = (nadd_reg == 2'd2) && (off_reg == 3'd7);

    // Decode of an accepted command: bits to append and pair state.
    always_comb
    begin
        add_n       = 2'd0;
        add_a       = 1'b0;
        add_b       = 1'b0;
        status_next = PS_NO_PAIR;
        dice_next   = 2'd0;
        pend_next   = pend_reg;
        first_next  = first_reg;
        unique case (op)
            OP_RAW:
            begin
                if (has_room)
                begin
                    add_n = 2'd1;
                    add_a = coin;
                end
            end
            OP_PAIR:
            begin
                if (!pend_reg)
                begin
                    pend_next   = 1'b1;
                    first_next  = coin;
                    status_next = PS_WAIT;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (first_reg == coin)
                    begin
                        status_next = PS_DROP;
                    end
                    else
                    begin
                        status_next = first_reg ? PS_ADD1 : PS_ADD0;
                        if (has_room)
                        begin
                            add_n = 2'd1;
                            add_a = first_reg;
                        end
                    end
                end
            end
            OP_DIE:
            begin
                if (tgt_ok && (total_ext < tgt_ext) && (value >= 8'd1) && (value <= 8'd4))
                begin
                    add_n     = 2'd1;
                    add_a     = code[1];
                    dice_next = 2'd1;
                    if (((total_ext + EXT_W'(1)) < tgt_ext) && (mod_reg != MOD_LAST))
                    begin
                        add_n     = 2'd2;
                        add_b     = code[0];
                        dice_next = 2'd2;
                    end
                end
            end
            OP_CLEAR:
            begin
                pend_next  = 1'b0;
                first_next = 1'b0;
            end
            default:
            begin
                add_n = 2'd0;
            end
        endcase
    end

    // Count and its residue by the die split after the append.
    always_comb
    begin
        mod_sum = mod_reg + MOD_W'(add_n);
        if (op == OP_CLEAR)
        begin
            total_next = '0;
            mod_next   = '0;
        end
        else
        begin
            total_next = total_reg + CNT_W'(add_n);
            mod_next   = (mod_sum >= DIE_SPLIT) ? (mod_sum - DIE_SPLIT) : mod_sum;
        end
        reached_next = tgt_ok && ({1'b0, total_next} >= tgt_ext);
    end

    // Command capture for the store update.
    always_comb
    begin
        nadd_next  = add_n;
        bit_a_next = add_a;
        bit_b_next = add_b;
        off_next   = total_reg[2:0];
        row_next   = total_reg[3 +: ROW_W];
        rd_op_next = (op == OP_READ) && ({1'b0, byte_index} < 6'(STORE_ROWS));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = spill ? ST_SPILL : ST_IDLE;
            end
            ST_SPILL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Bit masks for the tail row: the second die bit stays in the row
    // unless the first one filled it.
    always_comb
    begin
        mask_a = bit_a_reg ? (8'h80 >> off_reg) : 8'h00;
        mask_b = (bit_b_reg && (nadd_reg == 2'd2) && (off_reg != 3'd7))
               ? (8'h80 >> (off_reg + 3'd1)) : 8'h00;
    end

    // Store requests, read data capture and the result strobe.
    always_comb
    begin
        req        = '0;
        done_next  = 1'b0;
        rdata_next = rdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.rd_en  = accept;
                req.rd_row = (op == OP_READ) ? ROW_W'(byte_index) : total_reg[3 +: ROW_W];
                req.clr    = accept && (op == OP_CLEAR);
            end
            ST_EXEC:
            begin
                req.wr_en   = (nadd_reg != 2'd0);
                req.wr_row  = row_reg;
                req.wr_data = rd_data | mask_a | mask_b;
                rdata_next  = rd_op_reg ? rd_data : 8'h00;
                done_next   = !spill;
            end
            ST_SPILL:
            begin
                req.wr_en   = 1'b1;
                req.wr_row  = row_reg + ROW_W'(1);
                req.wr_data = {bit_b_reg, 7'b0};
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            target_reg <= TARGET_RESET;
            total_reg  <= '0;
            mod_reg    <= '0;
            pend_reg   <= 1'b0;
            first_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
            if (accept)
            begin
                total_reg <= total_next;
                mod_reg   <= mod_next;
                pend_reg  <= pend_next;
                first_reg <= first_next;
            end
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nadd_reg    <= nadd_next;
            bit_a_reg   <= bit_a_next;
            bit_b_reg   <= bit_b_next;
            off_reg     <= off_next;
            row_reg     <= row_next;
            rd_op_reg   <= rd_op_next;
            status_reg  <= status_next;
            dice_reg    <= dice_next;
            reached_reg <= reached_next;
        end
        rdata_reg <= rdata_next;
    end

    assign done            = done_reg;
    assign pair_status     = status_reg;
    assign dice_bits_added = dice_reg;
    assign bits_held       = total_reg;
    assign target_reached  = reached_reg;
    assign read_data       = rdata_reg;

endmodule

// ----- hdl/entropy_bit_collector_unit.sv -----
// ----------------------------------------------------------------------------
// entropy_bit_collector_unit
// Collects entropy bits (raw, von Neumann pairs, die rolls) in a row memory
// and reads them back a byte at a time.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  command   start / busy         op, value, byte_index
//  result    done (one cycle)     pair_status, dice_bits_added, bits_held,
//                                 target_reached, read_data
//  config    cfg_we               cfg_data (target length)
//
//  A command is taken when start is high and busy is low. Its result shows
//  with done after the EXEC state, which does the read-modify-write of the row, or
//  after the SPILL state when a die roll spills its second bit into the next row.
//  A new command may be taken in the cycle in which done is high.
//  Reset clears the row valid flags at once, so no clearing pass is needed.
//  The receiver cannot stall: each result is a single-cycle transfer.
// ----------------------------------------------------------------------------
module entropy_bit_collector_unit
    import ebc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       op,
    input  logic [7:0]       value,
    input  logic [4:0]       byte_index,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    output logic             done,
    output logic [2:0]       pair_status,
    output logic [1:0]       dice_bits_added,
    output logic [CNT_W-1:0] bits_held,
    output logic             target_reached,
    output logic [7:0]       read_data
);

    store_req_t req;
    logic [7:0] rd_data;

    // Sequencer and counters.
    ebc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .op              (op),
        .value           (value),
        .byte_index      (byte_index),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .rd_data         (rd_data),
        .busy            (busy),
        .done            (done),
        .pair_status     (pair_status),
        .dice_bits_added (dice_bits_added),
        .bits_held       (bits_held),
        .target_reached  (target_reached),
        .read_data       (read_data),
        .req             (req)
    );

    // Bit store.
    ebc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule
